>>> sv/point_histogram_accumulator_top_defines.svh
`ifndef POINT_HISTOGRAM_ACCUMULATOR_TOP_DEFINES_SVH
`define POINT_HISTOGRAM_ACCUMULATOR_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define PHACC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("phacc assertion failed");

// Antecedent implies consequent in the next cycle.
`define PHACC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("phacc assertion failed");

`endif

>>> sv/phacc_pkg.sv
`timescale 1ns / 1ps

package phacc_pkg;

  localparam int DEF_MAX_WIDTH       = 512;
  localparam int DEF_MAX_HEIGHT      = 512;
  localparam int DEF_COORD_FRAC_BITS = 12;

  localparam int CFG_W     = 10;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int PIX_W     = 9;
  localparam int HITS_W    = 32;
  localparam int FACTOR_W  = 48;
  localparam int CF_W      = 16;
  localparam int COORD_W   = 16;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(512);

  // Register index, taken from paddr[2].
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [1:0] MODE_PLOT  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] STAT_ADDED   = 2'd0;
  localparam logic [1:0] STAT_OOB     = 2'd1;
  localparam logic [1:0] STAT_READ    = 2'd2;
  localparam logic [1:0] STAT_CLEARED = 2'd3;

  typedef struct packed {
    logic load;    // capture an input beat
    logic clr_wr;  // write zero at the sweep pointer and advance
    logic wb;      // write back the pixel and load the output register
  } cmd_t;

  typedef struct packed {
    logic       sweep_last;
    logic       out_free;
    logic [1:0] mode;
  } dp_status_t;

endpackage

>>> sv/phacc_regs.sv
`timescale 1ns / 1ps

module phacc_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [phacc_pkg::PADDR_W-1:0]     paddr,
  input  logic [phacc_pkg::PDATA_W-1:0]     pwdata,
  output logic [phacc_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready,
  output logic [phacc_pkg::CFG_W-1:0]       image_width,
  output logic [phacc_pkg::CFG_W-1:0]       image_height
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= phacc_pkg::SIZE_RESET;
      image_height <= phacc_pkg::SIZE_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        phacc_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[phacc_pkg::CFG_W-1:0];
        phacc_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[phacc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      phacc_pkg::REG_IMAGE_WIDTH:  prdata = phacc_pkg::PDATA_W'(image_width);
      phacc_pkg::REG_IMAGE_HEIGHT: prdata = phacc_pkg::PDATA_W'(image_height);
      default:                     prdata = '0;
    endcase
  end

endmodule

>>> sv/phacc_dp.sv
`timescale 1ns / 1ps

module phacc_dp #(
  parameter int MAX_WIDTH       = phacc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = phacc_pkg::DEF_MAX_HEIGHT,
  parameter int COORD_FRAC_BITS = phacc_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  phacc_pkg::cmd_t                       cmd,
  output phacc_pkg::dp_status_t                 dp_status,
  input  logic [phacc_pkg::CFG_W-1:0]           image_width,
  input  logic [phacc_pkg::CFG_W-1:0]           image_height,
  input  logic [1:0]                            mode,
  input  logic signed [phacc_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [phacc_pkg::COORD_W-1:0]  pos_y,
  input  logic [phacc_pkg::CF_W-1:0]            color_factor,
  input  logic [phacc_pkg::PIX_W-1:0]           read_col,
  input  logic [phacc_pkg::PIX_W-1:0]           read_row,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            status,
  output logic [phacc_pkg::PIX_W-1:0]           pixel_col,
  output logic [phacc_pkg::PIX_W-1:0]           pixel_row,
  output logic [phacc_pkg::HITS_W-1:0]          hits,
  output logic [phacc_pkg::FACTOR_W-1:0]        factor_total
);

  localparam int HITS_W   = phacc_pkg::HITS_W;
  localparam int FACTOR_W = phacc_pkg::FACTOR_W;
  localparam int ENTRY_W  = HITS_W + FACTOR_W;
  localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SZX_W    = $clog2(MAX_WIDTH + 1);
  localparam int SZY_W    = $clog2(MAX_HEIGHT + 1);
  localparam int CMPX_W   = (SZX_W > phacc_pkg::CFG_W) ? SZX_W : phacc_pkg::CFG_W;
  localparam int CMPY_W   = (SZY_W > phacc_pkg::CFG_W) ? SZY_W : phacc_pkg::CFG_W;
  localparam int SW       = ((COORD_FRAC_BITS + 1 > phacc_pkg::COORD_W) ?
                             COORD_FRAC_BITS + 1 : phacc_pkg::COORD_W) + 1;
  localparam int PWX      = SW - 1 + SZX_W;
  localparam int PWY      = SW - 1 + SZY_W;
  localparam int RD_CMP_W = 32;

  // Input registers
  logic [1:0]                           mode_q;
  logic signed [phacc_pkg::COORD_W-1:0] pos_x_q;
  logic signed [phacc_pkg::COORD_W-1:0] pos_y_q;
  logic [phacc_pkg::CF_W-1:0]           cf_q;
  logic [phacc_pkg::PIX_W-1:0]          rcol_q;
  logic [phacc_pkg::PIX_W-1:0]          rrow_q;

  // Mapping
  logic [SZX_W-1:0]     size_w;
  logic [SZY_W-1:0]     size_h;
  logic signed [SW-1:0] sx;
  logic signed [SW-1:0] sy;
  logic [PWX-1:0]       prod_x;
  logic [PWY-1:0]       prod_y;
  logic                 neg_x;
  logic                 neg_y;
  logic [PWX-1:0]       pix_x;
  logic [PWY-1:0]       pix_y;
  logic                 in_x;
  logic                 in_y;

  // Lookup
  logic [COL_W-1:0]            look_col;
  logic [ROW_W-1:0]            look_row;
  logic                        look_ok;
  logic [ADDR_W-1:0]           look_addr;
  logic                        ok_q;
  logic [ADDR_W-1:0]           addr_q;
  logic [phacc_pkg::PIX_W-1:0] col_q;
  logic [phacc_pkg::PIX_W-1:0] row_q;

  // Store
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] mem_q;
  logic [ADDR_W-1:0]  sweep_cnt;
  logic               sweep_last;

  // Update
  logic [HITS_W-1:0]   old_hits;
  logic [FACTOR_W-1:0] old_factor;
  logic [HITS_W-1:0]   new_hits;
  logic [FACTOR_W:0]   factor_sum;
  logic [FACTOR_W-1:0] new_factor;
  logic                plot_wr;

  logic                        out_valid_next;
  logic [1:0]                  status_next;
  logic [phacc_pkg::PIX_W-1:0] col_next;
  logic [phacc_pkg::PIX_W-1:0] row_next;
  logic [HITS_W-1:0]           hits_next;
  logic [FACTOR_W-1:0]         factor_next;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q  <= mode;
      pos_x_q <= pos_x;
      pos_y_q <= pos_y;
      cf_q    <= color_factor;
      rcol_q  <= read_col;
      rrow_q  <= read_row;
    end
  end

  always_comb begin
    size_w = (CMPX_W'(image_width) > CMPX_W'(MAX_WIDTH)) ?
             SZX_W'(MAX_WIDTH) : SZX_W'(image_width);
    size_h = (CMPY_W'(image_height) > CMPY_W'(MAX_HEIGHT)) ?
             SZY_W'(MAX_HEIGHT) : SZY_W'(image_height);
    sx = SW'(pos_x_q) + (SW'(1) << COORD_FRAC_BITS);
    sy = SW'(pos_y_q) + (SW'(1) << COORD_FRAC_BITS);
  end

  // Scale the offset coordinate by the image size.
  always_ff @(posedge clk) begin
    neg_x  <= sx[SW-1];
    neg_y  <= sy[SW-1];
    prod_x <= PWX'(sx[SW-2:0]) * PWX'(size_w);
    prod_y <= PWY'(sy[SW-2:0]) * PWY'(size_h);
  end

  always_comb begin
    pix_x = prod_x >> (COORD_FRAC_BITS + 1);
    pix_y = prod_y >> (COORD_FRAC_BITS + 1);
    in_x  = !neg_x && (pix_x < PWX'(size_w));
    in_y  = !neg_y && (pix_y < PWY'(size_h));
    if (mode_q == phacc_pkg::MODE_PLOT) begin
      look_col = COL_W'(pix_x);
      look_row = ROW_W'(pix_y);
      look_ok  = in_x && in_y;
    end else begin
      look_col = COL_W'(rcol_q);
      look_row = ROW_W'(rrow_q);
      look_ok  = (RD_CMP_W'(rcol_q) < RD_CMP_W'(MAX_WIDTH)) &&
                 (RD_CMP_W'(rrow_q) < RD_CMP_W'(MAX_HEIGHT));
    end
    look_addr = ADDR_W'(look_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(look_col);
  end

  always_ff @(posedge clk) begin
    ok_q   <= look_ok;
    addr_q <= look_addr;
    col_q  <= phacc_pkg::PIX_W'(look_col);
    row_q  <= phacc_pkg::PIX_W'(look_row);
  end

  assign sweep_last = (sweep_cnt == ADDR_W'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.clr_wr) begin
      sweep_cnt <= sweep_last ? '0 : sweep_cnt + ADDR_W'(1);
    end
  end

  always_comb begin
    old_hits   = mem_q[ENTRY_W-1:FACTOR_W];
    old_factor = mem_q[FACTOR_W-1:0];
    new_hits   = (&old_hits) ? old_hits : old_hits + HITS_W'(1);
    factor_sum = {1'b0, old_factor} + (FACTOR_W + 1)'(cf_q);
    new_factor = factor_sum[FACTOR_W] ? {FACTOR_W{1'b1}} : factor_sum[FACTOR_W-1:0];
    plot_wr    = cmd.wb && (mode_q == phacc_pkg::MODE_PLOT) && ok_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[sweep_cnt] <= '0;
    end else if (plot_wr) begin
      mem[addr_q] <= {new_hits, new_factor};
    end
    mem_q <= mem[look_addr];
  end

  always_comb begin
    status_next = phacc_pkg::STAT_READ;
    col_next    = '0;
    row_next    = '0;
    hits_next   = '0;
    factor_next = '0;
    priority if (mode_q == phacc_pkg::MODE_PLOT) begin
      if (ok_q) begin
        status_next = phacc_pkg::STAT_ADDED;
        col_next    = col_q;
        row_next    = row_q;
        hits_next   = new_hits;
        factor_next = new_factor;
      end else begin
        status_next = phacc_pkg::STAT_OOB;
      end
    end else if (mode_q == phacc_pkg::MODE_CLEAR) begin
      status_next = phacc_pkg::STAT_CLEARED;
    end else begin
      col_next = rcol_q;
      row_next = rrow_q;
      if (ok_q) begin
        hits_next   = old_hits;
        factor_next = old_factor;
      end
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.wb) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      status       <= status_next;
      pixel_col    <= col_next;
      pixel_row    <= row_next;
      hits         <= hits_next;
      factor_total <= factor_next;
    end
  end

  assign dp_status.sweep_last = sweep_last;
  assign dp_status.out_free   = !out_valid || out_ready;
  assign dp_status.mode       = mode_q;

endmodule

>>> sv/phacc_ctrl.sv
`timescale 1ns / 1ps
`include "point_histogram_accumulator_top_defines.svh"

module phacc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  phacc_pkg::dp_status_t dp_status,
  output phacc_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_MAP,
    S_LOOK,
    S_WB
  } state_t;

  state_t state;
  logic   report;

  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.clr_wr = (state == S_SWEEP);
  assign cmd.wb     = (state == S_WB) && dp_status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_SWEEP;
      report <= 1'b0;
    end else begin
      unique case (state)
        S_SWEEP: begin
          if (dp_status.sweep_last) begin
            state  <= report ? S_WB : S_IDLE;
            report <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MAP;
          end
        end
        S_MAP: begin
          if (dp_status.mode == phacc_pkg::MODE_CLEAR) begin
            state  <= S_SWEEP;
            report <= 1'b1;
          end else begin
            state <= S_LOOK;
          end
        end
        S_LOOK: state <= S_WB;
        S_WB: begin
          // hold until the output register can take the result
          if (dp_status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PHACC_ASSERT_NEXT(a_accept_maps, clk, rst, cmd.load, state == S_MAP)
  `PHACC_ASSERT_NOW(a_wb_has_slot, clk, rst, cmd.wb, dp_status.out_free)
  `PHACC_ASSERT_NEXT(a_sweep_leaves, clk, rst, cmd.clr_wr && dp_status.sweep_last, state != S_SWEEP)
  `PHACC_ASSERT_NOW(a_report_in_sweep, clk, rst, report, state == S_SWEEP)

endmodule

>>> sv/point_histogram_accumulator_top.sv
`timescale 1ns / 1ps

// Point histogram accumulator. Plot beats map signed fixed-point (x,y) onto an
// image_width by image_height pixel grid and add one hit and the color factor
// to that pixel, both saturating; read beats return one pixel; clear beats zero
// the whole store. Plot and read beats are handled one at a time, in order:
// capture, size multiply, bounds check and store lookup, then write back into
// the output register once it is free, which frees the input side again. A
// clear beat occupies the block while the single write port sweeps the store
// one entry per cycle. After reset the same sweep runs with in_ready low;
// register writes are taken during it.
module point_histogram_accumulator_top #(
  parameter int MAX_WIDTH       = phacc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = phacc_pkg::DEF_MAX_HEIGHT,
  parameter int COORD_FRAC_BITS = phacc_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [phacc_pkg::PADDR_W-1:0]         paddr,
  input  logic [phacc_pkg::PDATA_W-1:0]         pwdata,
  output logic [phacc_pkg::PDATA_W-1:0]         prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            mode,
  input  logic signed [phacc_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [phacc_pkg::COORD_W-1:0]  pos_y,
  input  logic [phacc_pkg::CF_W-1:0]            color_factor,
  input  logic [phacc_pkg::PIX_W-1:0]           read_col,
  input  logic [phacc_pkg::PIX_W-1:0]           read_row,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            status,
  output logic [phacc_pkg::PIX_W-1:0]           pixel_col,
  output logic [phacc_pkg::PIX_W-1:0]           pixel_row,
  output logic [phacc_pkg::HITS_W-1:0]          hits,
  output logic [phacc_pkg::FACTOR_W-1:0]        factor_total
);

  logic [phacc_pkg::CFG_W-1:0] image_width;
  logic [phacc_pkg::CFG_W-1:0] image_height;
  phacc_pkg::cmd_t             cmd;
  phacc_pkg::dp_status_t       dp_status;

  phacc_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .image_width  (image_width),
    .image_height (image_height)
  );

  phacc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  phacc_dp #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .dp_status    (dp_status),
    .image_width  (image_width),
    .image_height (image_height),
    .mode         (mode),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .color_factor (color_factor),
    .read_col     (read_col),
    .read_row     (read_row),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .pixel_col    (pixel_col),
    .pixel_row    (pixel_row),
    .hits         (hits),
    .factor_total (factor_total)
  );

endmodule

>>> sim/point_histogram_accumulator_top_test.sv
`timescale 1ns / 1ps

module point_histogram_accumulator_top_test;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned TAIL_CYCLES = 20;
  // The fourth mode code is not named in the package; the block treats it as a read.
  localparam logic [1:0]  MODE_SPARE  = 2'd3;

  typedef struct packed {
    logic [1:0]                     status;
    logic [phacc_pkg::PIX_W-1:0]    col;
    logic [phacc_pkg::PIX_W-1:0]    row;
    logic [phacc_pkg::HITS_W-1:0]   hits;
    logic [phacc_pkg::FACTOR_W-1:0] factor;
  } pixel_report_t;

  class pixel_tally;
    bit [phacc_pkg::HITS_W-1:0]    hit_count[int];
    bit [phacc_pkg::FACTOR_W-1:0]  factor_sum[int];
    logic [phacc_pkg::CFG_W-1:0]   cols_in_use;
    logic [phacc_pkg::CFG_W-1:0]   rows_in_use;
    pixel_report_t                 report_q[$];
    logic [2*phacc_pkg::PIX_W-1:0] touched_q[$];
    int                            mismatches;
    int                            added;
    int                            skipped;
    int                            reads;
    int                            clears;

    function new();
      cols_in_use = phacc_pkg::SIZE_RESET;
      rows_in_use = phacc_pkg::SIZE_RESET;
    endfunction

    function void set_size(logic idx, logic [phacc_pkg::PDATA_W-1:0] value);
      if (idx == phacc_pkg::REG_IMAGE_WIDTH) cols_in_use = value[phacc_pkg::CFG_W-1:0];
      else rows_in_use = value[phacc_pkg::CFG_W-1:0];
    endfunction

    // Map a Q3.12 coordinate onto [0, size); sizes above the store act as the store size.
    function bit place(logic signed [phacc_pkg::COORD_W-1:0] coord,
                       logic [phacc_pkg::CFG_W-1:0] reg_size, int unsigned store_size,
                       output logic [phacc_pkg::PIX_W-1:0] pix);
      longint shifted;
      longint scaled;
      longint span;
      span = (reg_size > store_size) ? longint'(store_size) : longint'(reg_size);
      shifted = longint'(coord) + (longint'(1) << phacc_pkg::DEF_COORD_FRAC_BITS);
      pix = '0;
      if (shifted < 0) return 0;
      scaled = (shifted * span) >>> (phacc_pkg::DEF_COORD_FRAC_BITS + 1);
      if (scaled >= span) return 0;
      pix = scaled[phacc_pkg::PIX_W-1:0];
      return 1;
    endfunction

    function void note_beat(logic [1:0] m, logic signed [phacc_pkg::COORD_W-1:0] x,
                            logic signed [phacc_pkg::COORD_W-1:0] y,
                            logic [phacc_pkg::CF_W-1:0] cf,
                            logic [phacc_pkg::PIX_W-1:0] rc,
                            logic [phacc_pkg::PIX_W-1:0] rr);
      pixel_report_t                 r;
      logic [phacc_pkg::PIX_W-1:0]   pcol;
      logic [phacc_pkg::PIX_W-1:0]   prow;
      int                            a;
      logic [phacc_pkg::FACTOR_W:0]  f;
      r = '0;
      case (m)
        phacc_pkg::MODE_PLOT: begin
          if (place(x, cols_in_use, phacc_pkg::DEF_MAX_WIDTH, pcol) &&
              place(y, rows_in_use, phacc_pkg::DEF_MAX_HEIGHT, prow)) begin
            a = int'(prow) * phacc_pkg::DEF_MAX_WIDTH + int'(pcol);
            if (!hit_count.exists(a)) begin
              hit_count[a] = '0;
              factor_sum[a] = '0;
            end
            if (hit_count[a] != '1) hit_count[a] = hit_count[a] + 1'b1;
            f = factor_sum[a] + cf;
            factor_sum[a] = f[phacc_pkg::FACTOR_W] ? '1 : f[phacc_pkg::FACTOR_W-1:0];
            r.status = phacc_pkg::STAT_ADDED;
            r.col = pcol;
            r.row = prow;
            r.hits = hit_count[a];
            r.factor = factor_sum[a];
            touched_q.push_back({prow, pcol});
            if (touched_q.size() > 64) void'(touched_q.pop_front());
            added++;
          end else begin
            r.status = phacc_pkg::STAT_OOB;
            skipped++;
          end
        end
        phacc_pkg::MODE_CLEAR: begin
          hit_count.delete();
          factor_sum.delete();
          touched_q.delete();
          r.status = phacc_pkg::STAT_CLEARED;
          clears++;
        end
        default: begin
          a = int'(rr) * phacc_pkg::DEF_MAX_WIDTH + int'(rc);
          r.status = phacc_pkg::STAT_READ;
          r.col = rc;
          r.row = rr;
          if (hit_count.exists(a)) begin
            r.hits = hit_count[a];
            r.factor = factor_sum[a];
          end
          reads++;
        end
      endcase
      report_q.push_back(r);
    endfunction

    function void complain(string what, pixel_report_t want, pixel_report_t got);
      mismatches++;
      if (mismatches <= 10)
        $display({"%s: expected status %0d col %0d row %0d hits %0d factor %h,",
                  " got status %0d col %0d row %0d hits %0d factor %h"},
                 what, want.status, want.col, want.row, want.hits, want.factor,
                 got.status, got.col, got.row, got.hits, got.factor);
    endfunction

    function void check_report(pixel_report_t got);
      pixel_report_t want;
      if (report_q.size() == 0) begin
        complain("result with nothing outstanding", '0, got);
        return;
      end
      want = report_q.pop_front();
      if (got.status !== want.status) complain("status mismatch", want, got);
      else if (got.col !== want.col) complain("pixel_col mismatch", want, got);
      else if (got.row !== want.row) complain("pixel_row mismatch", want, got);
      else if (got.hits !== want.hits) complain("hits mismatch", want, got);
      else if (got.factor !== want.factor) complain("factor_total mismatch", want, got);
    endfunction

    function void check_size(logic idx, logic [phacc_pkg::PDATA_W-1:0] got);
      logic [phacc_pkg::PDATA_W-1:0] want;
      want = phacc_pkg::PDATA_W'(idx == phacc_pkg::REG_IMAGE_WIDTH ? cols_in_use
                                                                   : rows_in_use);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("register %0d readback: expected %0d, got %0d", idx, want, got);
      end
    endfunction

    function logic [2*phacc_pkg::PIX_W-1:0] recall_pixel();
      if (touched_q.size() == 0) return (2*phacc_pkg::PIX_W)'($urandom);
      return touched_q[$urandom_range(0, touched_q.size() - 1)];
    endfunction
  endclass

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 psel = 1'b0;
  logic                                 penable = 1'b0;
  logic                                 pwrite = 1'b0;
  logic [phacc_pkg::PADDR_W-1:0]        paddr = '0;
  logic [phacc_pkg::PDATA_W-1:0]        pwdata = '0;
  logic [phacc_pkg::PDATA_W-1:0]        prdata;
  logic                                 pready;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic [1:0]                           mode = phacc_pkg::MODE_PLOT;
  logic signed [phacc_pkg::COORD_W-1:0] pos_x = '0;
  logic signed [phacc_pkg::COORD_W-1:0] pos_y = '0;
  logic [phacc_pkg::CF_W-1:0]           color_factor = '0;
  logic [phacc_pkg::PIX_W-1:0]          read_col = '0;
  logic [phacc_pkg::PIX_W-1:0]          read_row = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic [1:0]                           status;
  logic [phacc_pkg::PIX_W-1:0]          pixel_col;
  logic [phacc_pkg::PIX_W-1:0]          pixel_row;
  logic [phacc_pkg::HITS_W-1:0]         hits;
  logic [phacc_pkg::FACTOR_W-1:0]       factor_total;

  pixel_tally                           book;
  int unsigned                          cycles = 0;
  int                                   send_calm = 0;
  int                                   drain_calm = 0;
  int                                   results_seen = 0;
  int                                   size_settings = 0;
  logic signed [phacc_pkg::COORD_W-1:0] last_x = '0;
  logic signed [phacc_pkg::COORD_W-1:0] last_y = '0;

  point_histogram_accumulator_top u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Idle cycles before the next beat; occasionally run a stretch with none.
  function automatic int draw_pause(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic logic signed [phacc_pkg::COORD_W-1:0] pick_coord();
    int v;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: v = ($urandom_range(0, 1) ? 4096 : -4096) + int'($urandom_range(0, 8)) - 4;
      default: v = int'($urandom_range(0, 8191)) - 4096;
    endcase
    return v[phacc_pkg::COORD_W-1:0];
  endfunction

  function automatic logic signed [phacc_pkg::COORD_W-1:0] any_coord();
    return phacc_pkg::COORD_W'($urandom);
  endfunction

  function automatic logic [phacc_pkg::CF_W-1:0] any_cf();
    return phacc_pkg::CF_W'($urandom);
  endfunction

  function automatic logic [phacc_pkg::PIX_W-1:0] any_pix();
    return phacc_pkg::PIX_W'($urandom);
  endfunction

  task automatic send_beat(input logic [1:0] m,
                           input logic signed [phacc_pkg::COORD_W-1:0] x,
                           input logic signed [phacc_pkg::COORD_W-1:0] y,
                           input logic [phacc_pkg::CF_W-1:0] cf,
                           input logic [phacc_pkg::PIX_W-1:0] rc,
                           input logic [phacc_pkg::PIX_W-1:0] rr);
    int gap;
    gap = draw_pause(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mode <= m;
    pos_x <= x;
    pos_y <= y;
    color_factor <= cf;
    read_col <= rc;
    read_row <= rr;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    book.note_beat(m, x, y, cf, rc, rr);
  endtask

  task automatic write_reg(input logic idx, input logic [phacc_pkg::PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    book.set_size(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic confirm_reg(input logic idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    book.check_size(idx, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, let every outstanding result come back, then set a new image size.
  task automatic resize(input int unsigned w, input int unsigned h);
    in_valid <= 1'b0;
    while (book.report_q.size() != 0) @(posedge clk);
    write_reg(phacc_pkg::REG_IMAGE_WIDTH, ($urandom & ~32'h3FF) | w);
    write_reg(phacc_pkg::REG_IMAGE_HEIGHT, ($urandom & ~32'h3FF) | h);
    confirm_reg(phacc_pkg::REG_IMAGE_WIDTH);
    confirm_reg(phacc_pkg::REG_IMAGE_HEIGHT);
    size_settings++;
  endtask

  task automatic random_beat();
    int                                   pick;
    logic [1:0]                           m;
    logic signed [phacc_pkg::COORD_W-1:0] x;
    logic signed [phacc_pkg::COORD_W-1:0] y;
    logic [phacc_pkg::CF_W-1:0]           cf;
    logic [2*phacc_pkg::PIX_W-1:0]        spot;
    pick = $urandom_range(0, 99);
    x = any_coord();
    y = any_coord();
    cf = any_cf();
    spot = (2*phacc_pkg::PIX_W)'($urandom);
    m = phacc_pkg::MODE_PLOT;
    if (pick < 72) begin
      // Revisit the last point now and then so pixels build up.
      if ($urandom_range(0, 3) == 0) begin
        x = last_x;
        y = last_y;
      end else begin
        x = pick_coord();
        y = pick_coord();
      end
      last_x = x;
      last_y = y;
      case ($urandom_range(0, 9))
        0: cf = '0;
        1: cf = '1;
        default: ;
      endcase
    end else if (pick < 92) begin
      m = phacc_pkg::MODE_READ;
      if ($urandom_range(0, 2) != 0) spot = book.recall_pixel();
    end else if (pick < 97) begin
      m = MODE_SPARE;
      if ($urandom_range(0, 1) != 0) spot = book.recall_pixel();
    end
    send_beat(m, x, y, cf, spot[phacc_pkg::PIX_W-1:0],
              spot[2*phacc_pkg::PIX_W-1:phacc_pkg::PIX_W]);
  endtask

  task automatic run_phase(input int unsigned w, input int unsigned h, input int count,
                           input int clear_at);
    resize(w, h);
    for (int i = 0; i < count; i++) begin
      if (i == clear_at)
        send_beat(phacc_pkg::MODE_CLEAR, any_coord(), any_coord(), any_cf(), any_pix(),
                  any_pix());
      else random_beat();
    end
  endtask

  initial begin : drain_results
    int            stall;
    pixel_report_t seen;
    while (rst) @(posedge clk);
    forever begin
      // Hold off twice for a long stretch so the block backs up into its input.
      if (results_seen == 500 || results_seen == 1400) stall = LONG_HOLD;
      else stall = draw_pause(drain_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      seen.status = status;
      seen.col = pixel_col;
      seen.row = pixel_row;
      seen.hits = hits;
      seen.factor = factor_total;
      book.check_report(seen);
      results_seen++;
    end
  end

  initial begin : stimulus
    book = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    confirm_reg(phacc_pkg::REG_IMAGE_WIDTH);
    confirm_reg(phacc_pkg::REG_IMAGE_HEIGHT);

    // Default 512 x 512 grid: center, corners, edges of the nominal range.
    send_beat(phacc_pkg::MODE_PLOT, 16'sd0, 16'sd0, 16'hFFFF, any_pix(), any_pix());
    send_beat(phacc_pkg::MODE_PLOT, 16'sd0, 16'sd0, 16'h0001, any_pix(), any_pix());
    send_beat(phacc_pkg::MODE_PLOT, -16'sd4096, 16'sd4095, 16'h8000, any_pix(), any_pix());
    send_beat(phacc_pkg::MODE_PLOT, 16'sd4096, 16'sd0, 16'h1234, any_pix(), any_pix());
    send_beat(phacc_pkg::MODE_PLOT, -16'sd4097, 16'sd0, 16'h1234, any_pix(), any_pix());
    send_beat(phacc_pkg::MODE_PLOT, -16'sd32768, 16'sd32767, 16'hFFFF, any_pix(),
              any_pix());
    send_beat(phacc_pkg::MODE_PLOT, 16'sd32767, -16'sd32768, 16'hFFFF, any_pix(),
              any_pix());
    send_beat(phacc_pkg::MODE_READ, any_coord(), any_coord(), any_cf(), 9'd256, 9'd256);
    send_beat(phacc_pkg::MODE_READ, any_coord(), any_coord(), any_cf(), 9'd511, 9'd511);
    send_beat(MODE_SPARE, any_coord(), any_coord(), any_cf(), 9'd0, 9'd511);
    send_beat(phacc_pkg::MODE_CLEAR, any_coord(), any_coord(), any_cf(), any_pix(),
              any_pix());
    send_beat(phacc_pkg::MODE_READ, any_coord(), any_coord(), any_cf(), 9'd256, 9'd256);
    send_beat(phacc_pkg::MODE_PLOT, 16'sd4095, -16'sd4096, 16'h0000, any_pix(), any_pix());

    // Zero width rejects every point; the store survives a size change.
    resize(0, 512);
    send_beat(phacc_pkg::MODE_PLOT, 16'sd0, 16'sd0, 16'h4321, any_pix(), any_pix());
    send_beat(phacc_pkg::MODE_READ, any_coord(), any_coord(), any_cf(), 9'd511, 9'd0);

    resize(1, 1);
    send_beat(phacc_pkg::MODE_PLOT, 16'sd4095, 16'sd4095, 16'hFFFF, any_pix(), any_pix());
    send_beat(phacc_pkg::MODE_PLOT, -16'sd4096, -16'sd4096, 16'hFFFF, any_pix(),
              any_pix());

    // Sizes above the store clip to it.
    resize(1023, 1023);
    send_beat(phacc_pkg::MODE_PLOT, 16'sd4095, 16'sd4095, 16'h0100, any_pix(), any_pix());
    send_beat(phacc_pkg::MODE_PLOT, 16'sd4096, 16'sd0, 16'h0100, any_pix(), any_pix());

    resize(3, 5);
    send_beat(phacc_pkg::MODE_PLOT, 16'sd0, 16'sd0, 16'h00FF, any_pix(), any_pix());
    send_beat(phacc_pkg::MODE_READ, any_coord(), any_coord(), any_cf(), 9'd1, 9'd2);

    run_phase(512, 512, 400, -1);
    run_phase(1, 1, 150, -1);
    run_phase(0, 512, 80, -1);
    run_phase(1023, 1023, 350, 175);
    run_phase(300, 7, 250, -1);
    run_phase($urandom_range(1, 512), $urandom_range(1, 512), 350, -1);
    run_phase(512, 1, 120, -1);
    run_phase(7, 512, 250, -1);

    in_valid <= 1'b0;
    while (book.report_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Plotted %0d points on the image and %0d off it, %0d pixel reads, %0d clears,",
             book.added, book.skipped, book.reads, book.clears);
    $display("over %0d image sizes with %0d mismatches in %0d cycles.",
             size_settings, book.mismatches, cycles);
    if (book.mismatches == 0 && book.report_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
